FILE: hdl/tnts_pkg.sv
// Shared constants for the traction normal/tangential split pipeline.
// Stand-alone package; used by the channel interfaces and the top level.
`default_nettype none
package tnts_pkg;

  // Spatial axes of the normal and traction vectors.
  localparam int AXES = 3;

  // Integer bits of the normal code (sign plus one), so fraction = width - 2.
  localparam int NORMAL_INT_BITS = 2;

  // Register stages from the input request to the output register.
  localparam int PIPE_STAGES = 6;

  // Default widths of the channel fields.
  localparam int STRESS_WIDTH_DEF = 32;
  localparam int NORMAL_WIDTH_DEF = 16;

endpackage
`default_nettype wire

FILE: hdl/tnts_in_if.sv
// Input channel: one stress tensor (upper triangle) and one normal per request.
// Depends on tnts_pkg for default field widths.
`default_nettype none
interface tnts_in_if #(
  parameter int STRESS_WIDTH = tnts_pkg::STRESS_WIDTH_DEF,
  parameter int NORMAL_WIDTH = tnts_pkg::NORMAL_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [STRESS_WIDTH-1:0] s_xx;
  logic signed [STRESS_WIDTH-1:0] s_xy;
  logic signed [STRESS_WIDTH-1:0] s_xz;
  logic signed [STRESS_WIDTH-1:0] s_yy;
  logic signed [STRESS_WIDTH-1:0] s_yz;
  logic signed [STRESS_WIDTH-1:0] s_zz;
  logic signed [NORMAL_WIDTH-1:0] n_x;
  logic signed [NORMAL_WIDTH-1:0] n_y;
  logic signed [NORMAL_WIDTH-1:0] n_z;

  modport source (
    output valid, s_xx, s_xy, s_xz, s_yy, s_yz, s_zz, n_x, n_y, n_z,
    input  ready
  );
  modport sink (
    input  valid, s_xx, s_xy, s_xz, s_yy, s_yz, s_zz, n_x, n_y, n_z,
    output ready
  );
endinterface
`default_nettype wire

FILE: hdl/tnts_out_if.sv
// Result channel: normal stress and tangential traction per request.
// Depends on tnts_pkg for the default field width.
`default_nettype none
interface tnts_out_if #(
  parameter int STRESS_WIDTH = tnts_pkg::STRESS_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [STRESS_WIDTH-1:0] normal_stress;
  logic signed [STRESS_WIDTH-1:0] tangent_x;
  logic signed [STRESS_WIDTH-1:0] tangent_y;
  logic signed [STRESS_WIDTH-1:0] tangent_z;

  modport source (
    output valid, normal_stress, tangent_x, tangent_y, tangent_z,
    input  ready
  );
  modport sink (
    input  valid, normal_stress, tangent_x, tangent_y, tangent_z,
    output ready
  );
endinterface
`default_nettype wire

FILE: hdl/traction_normal_tangential_split_unit.sv
// Top level: splits the traction S*n into normal stress and tangential part.
// Depends on tnts_pkg, tnts_in_if and tnts_out_if.
//
//  channel | port   | dir | payload
//  --------+--------+-----+--------------------------------------------------
//  input   | in_ch  | in  | s_xx s_xy s_xz s_yy s_yz s_zz, n_x n_y n_z
//  result  | out_ch | out | normal_stress, tangent_x tangent_y tangent_z
//
// Six register stages: S*n products, traction round, t*n products, sigma round,
// sigma*n products, projection round/subtract/saturate into the output register.
// One request per cycle while the result channel takes results.
// Each stage has its own valid bit; a stage loads whenever it is empty or the
// stage after it moves, so bubbles close up and a stalled result holds in place.
// rst_n (synchronous, active low) clears the valid bits only.
`default_nettype none
module traction_normal_tangential_split_unit #(
  parameter int STRESS_WIDTH = 32,
  parameter int NORMAL_WIDTH = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tnts_in_if.sink     in_ch,
  tnts_out_if.source  out_ch
);

  localparam int AX   = tnts_pkg::AXES;
  localparam int NSTG = tnts_pkg::PIPE_STAGES;
  localparam int LAST = NSTG - 1;
  localparam int SW   = STRESS_WIDTH;
  localparam int NW   = NORMAL_WIDTH;
  localparam int NF   = NW - tnts_pkg::NORMAL_INT_BITS;

  localparam int PW   = SW + NW;       // stress * normal product
  localparam int PSW  = PW + 2;        // sum of three products
  localparam int TW   = SW + 3;        // traction, exact
  localparam int QW   = TW + NW;       // traction * normal product
  localparam int QSW  = QW + 2;
  localparam int GW   = SW + 6;        // sigma, exact
  localparam int RW   = GW + NW;       // sigma * normal product
  localparam int RSW  = RW + 1;
  localparam int DW   = SW + 9;        // traction minus projection

  localparam logic signed [PSW-1:0] HALF_P = PSW'(1) <<< (NF - 1);
  localparam logic signed [QSW-1:0] HALF_Q = QSW'(1) <<< (NF - 1);
  localparam logic signed [RSW-1:0] HALF_R = RSW'(1) <<< (NF - 1);

  function automatic logic signed [SW-1:0] sat_sw(input logic signed [DW-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[DW-1:SW-1];
    hi_zeros = ~|v[DW-1:SW-1];
    if (hi_ones || hi_zeros) begin
      sat_sw = v[SW-1:0];
    end else if (v[DW-1]) begin
      sat_sw = {1'b1, {(SW-1){1'b0}}};
    end else begin
      sat_sw = {1'b0, {(SW-1){1'b1}}};
    end
  endfunction

  // Handshake chain
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] stage_en;

  always_comb begin
    stage_en[LAST] = !v_r[LAST] || out_ch.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      stage_en[k] = !v_r[k] || stage_en[k+1];
    end
  end

  assign in_ch.ready = stage_en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (stage_en[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (stage_en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Input unpacking into the full symmetric matrix
  logic signed [SW-1:0] s_m [AX][AX];
  logic signed [NW-1:0] n_in [AX];

  always_comb begin
    s_m[0][0] = SW'(in_ch.s_xx);
    s_m[0][1] = SW'(in_ch.s_xy);
    s_m[0][2] = SW'(in_ch.s_xz);
    s_m[1][0] = SW'(in_ch.s_xy);
    s_m[1][1] = SW'(in_ch.s_yy);
    s_m[1][2] = SW'(in_ch.s_yz);
    s_m[2][0] = SW'(in_ch.s_xz);
    s_m[2][1] = SW'(in_ch.s_yz);
    s_m[2][2] = SW'(in_ch.s_zz);
    n_in[0]   = NW'(in_ch.n_x);
    n_in[1]   = NW'(in_ch.n_y);
    n_in[2]   = NW'(in_ch.n_z);
  end

  // Stage registers
  logic signed [PW-1:0] p0_r [AX][AX];
  logic signed [NW-1:0] n0_r [AX];
  logic signed [TW-1:0] t1_r [AX];
  logic signed [NW-1:0] n1_r [AX];
  logic signed [QW-1:0] q2_r [AX];
  logic signed [TW-1:0] t2_r [AX];
  logic signed [NW-1:0] n2_r [AX];
  logic signed [GW-1:0] g3_r;
  logic signed [TW-1:0] t3_r [AX];
  logic signed [NW-1:0] n3_r [AX];
  logic signed [RW-1:0] r4_r [AX];
  logic signed [TW-1:0] t4_r [AX];
  logic signed [SW-1:0] ns5_r;
  logic signed [SW-1:0] tg5_r [AX];

  logic signed [PW-1:0] p0_nxt [AX][AX];
  logic signed [TW-1:0] t1_nxt [AX];
  logic signed [QW-1:0] q2_nxt [AX];
  logic signed [GW-1:0] g3_nxt;
  logic signed [RW-1:0] r4_nxt [AX];
  logic signed [SW-1:0] ns5_nxt;
  logic signed [SW-1:0] tg5_nxt [AX];

  logic signed [PSW-1:0] tsum [AX];
  logic signed [PSW-1:0] tsh  [AX];
  logic signed [QSW-1:0] gsum;
  logic signed [QSW-1:0] gsh;
  logic signed [RSW-1:0] rsum [AX];
  logic signed [RSW-1:0] rsh  [AX];
  logic signed [DW-1:0]  diff [AX];

  always_comb begin
    for (int i = 0; i < AX; i++) begin
      for (int j = 0; j < AX; j++) begin
        p0_nxt[i][j] = PW'(s_m[i][j]) * PW'(n_in[j]);
      end
    end

    // round half up: add half an LSB, arithmetic shift down
    for (int i = 0; i < AX; i++) begin
      tsum[i]   = PSW'(p0_r[i][0]) + PSW'(p0_r[i][1]) + PSW'(p0_r[i][2]) + HALF_P;
      tsh[i]    = tsum[i] >>> NF;
      t1_nxt[i] = tsh[i][TW-1:0];
      q2_nxt[i] = QW'(t1_r[i]) * QW'(n1_r[i]);
    end

    gsum   = QSW'(q2_r[0]) + QSW'(q2_r[1]) + QSW'(q2_r[2]) + HALF_Q;
    gsh    = gsum >>> NF;
    g3_nxt = gsh[GW-1:0];

    for (int i = 0; i < AX; i++) begin
      r4_nxt[i]  = RW'(g3_r) * RW'(n3_r[i]);
      rsum[i]    = RSW'(r4_r[i]) + HALF_R;
      rsh[i]     = rsum[i] >>> NF;
      diff[i]    = DW'(t4_r[i]) - rsh[i][DW-1:0];
      tg5_nxt[i] = sat_sw(diff[i]);
    end
  end

  // sigma rides along from stage 3 with the products
  logic signed [GW-1:0] g4_r;

  always_comb begin
    ns5_nxt = sat_sw(DW'(g4_r));
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      p0_r <= p0_nxt;
      n0_r <= n_in;
    end
    if (stage_en[1]) begin
      t1_r <= t1_nxt;
      n1_r <= n0_r;
    end
    if (stage_en[2]) begin
      q2_r <= q2_nxt;
      t2_r <= t1_r;
      n2_r <= n1_r;
    end
    if (stage_en[3]) begin
      g3_r <= g3_nxt;
      t3_r <= t2_r;
      n3_r <= n2_r;
    end
    if (stage_en[4]) begin
      r4_r <= r4_nxt;
      t4_r <= t3_r;
      g4_r <= g3_r;
    end
    if (stage_en[5]) begin
      ns5_r <= ns5_nxt;
      tg5_r <= tg5_nxt;
    end
  end

  assign out_ch.valid         = v_r[LAST];
  assign out_ch.normal_stress = ns5_r;
  assign out_ch.tangent_x     = tg5_r[0];
  assign out_ch.tangent_y     = tg5_r[1];
  assign out_ch.tangent_z     = tg5_r[2];

  // Input backs up only when every stage holds an item.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r))
    else $error("input stalled while a pipeline stage is empty");

  // A blocked middle stage keeps its item.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[2] && !stage_en[2]) |=> v_r[2])
    else $error("stalled stage dropped its item");

  // An item in the first stage moves on whenever the next stage loads.
  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[0] && stage_en[1]) |=> v_r[1])
    else $error("item lost between first and second stage");

endmodule
`default_nettype wire

FILE: tb/sv/traction_normal_tangential_split_unit_test.sv
// Self-checking bench for traction_normal_tangential_split_unit: directed table, then random
// stress/normal requests with random stalls on both channels, checked against a local predictor.
// Depends on tnts_pkg, tnts_in_if, tnts_out_if and the unit itself.
module traction_normal_tangential_split_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW         = tnts_pkg::STRESS_WIDTH_DEF;
  localparam int NW         = tnts_pkg::NORMAL_WIDTH_DEF;
  localparam int NFRAC      = NW - tnts_pkg::NORMAL_INT_BITS;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_PHASE = 500;

  typedef logic signed [SW-1:0] stress_t;
  typedef logic signed [NW-1:0] normal_t;

  typedef struct packed {
    stress_t xx, xy, xz, yy, yz, zz;
    normal_t nx, ny, nz;
  } tensor_req_t;

  typedef struct packed {
    stress_t sigma, tx, ty, tz;
  } split_res_t;

  typedef struct packed {
    tensor_req_t req;
    logic        typed;
    split_res_t  res;
  } split_row_t;

  localparam stress_t SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam stress_t SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam normal_t NMIN = {1'b1, {(NW-1){1'b0}}};
  localparam normal_t NMAX = {1'b0, {(NW-1){1'b1}}};
  localparam normal_t NONE = normal_t'(1 << NFRAC);
  localparam stress_t SONE = stress_t'(65536);

  logic clk;
  logic rst_n;

  tnts_in_if  in_ch ();
  tnts_out_if out_ch ();

  traction_normal_tangential_split_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  split_res_t expected_splits[$];
  split_row_t dir_table[$];
  bit         src_idle;
  bit         snk_idle;
  int         n_sent;
  int         n_checked;
  int         n_errors;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // round half up at the normal's fraction
  function automatic longint round_q(longint acc);
    return (acc + (longint'(1) <<< (NFRAC - 1))) >>> NFRAC;
  endfunction

  function automatic stress_t sat_stress(longint v);
    longint hi = (longint'(1) <<< (SW - 1)) - 1;
    if (v > hi) return SMAX;
    if (v < -hi - 1) return SMIN;
    return stress_t'(v);
  endfunction

  function automatic split_res_t predict_split(tensor_req_t r);
    longint sxx, sxy, sxz, syy, syz, szz, nx, ny, nz, tx, ty, tz, sigma;
    split_res_t p;
    sxx = longint'($signed(r.xx));
    sxy = longint'($signed(r.xy));
    sxz = longint'($signed(r.xz));
    syy = longint'($signed(r.yy));
    syz = longint'($signed(r.yz));
    szz = longint'($signed(r.zz));
    nx  = longint'($signed(r.nx));
    ny  = longint'($signed(r.ny));
    nz  = longint'($signed(r.nz));
    // traction and sigma stay exact; only the outputs clamp
    tx = round_q(sxx * nx + sxy * ny + sxz * nz);
    ty = round_q(sxy * nx + syy * ny + syz * nz);
    tz = round_q(sxz * nx + syz * ny + szz * nz);
    sigma = round_q(tx * nx + ty * ny + tz * nz);
    p.sigma = sat_stress(sigma);
    p.tx = sat_stress(tx - round_q(sigma * nx));
    p.ty = sat_stress(ty - round_q(sigma * ny));
    p.tz = sat_stress(tz - round_q(sigma * nz));
    return p;
  endfunction

  function automatic stress_t rand_stress(int kind);
    case (kind)
      0: return stress_t'($urandom);
      1: return stress_t'(int'($urandom_range(0, 2097152)) - 1048576);
      2: return stress_t'(int'($urandom_range(0, 512)) - 256);
      default: begin
        case ($urandom_range(0, 4))
          0: return SMAX;
          1: return SMIN;
          2: return '0;
          3: return stress_t'(-1);
          default: return stress_t'(1);
        endcase
      end
    endcase
  endfunction

  function automatic normal_t rand_normal(int kind);
    case (kind)
      0: return normal_t'($urandom);
      1, 2: return normal_t'(int'($urandom_range(0, 32768)) - 16384);
      default: begin
        case ($urandom_range(0, 4))
          0: return NMIN;
          1: return NMAX;
          2: return '0;
          3: return NONE;
          default: return -NONE;
        endcase
      end
    endcase
  endfunction

  function automatic int draw_kind();
    int k;
    k = $urandom_range(0, 9);
    if (k < 4) return 0;
    if (k < 7) return 1;
    if (k < 9) return 2;
    return 3;
  endfunction

  function automatic tensor_req_t rand_tensor();
    tensor_req_t r;
    int sk, nk;
    sk = draw_kind();
    nk = draw_kind();
    r.xx = rand_stress(sk);
    r.xy = rand_stress(sk);
    r.xz = rand_stress(sk);
    r.yy = rand_stress(sk);
    r.yz = rand_stress(sk);
    r.zz = rand_stress(sk);
    r.nx = rand_normal(nk);
    r.ny = rand_normal(nk);
    r.nz = rand_normal(nk);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    n_errors++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, stress_t got, stress_t want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %h want %h", n_checked, name, got, want));
  endtask

  // called right after a rising edge; returns at the edge that takes the request
  task automatic send_req(tensor_req_t r, split_res_t e);
    int gap;
    gap = src_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.s_xx  <= r.xx;
    in_ch.s_xy  <= r.xy;
    in_ch.s_xz  <= r.xz;
    in_ch.s_yy  <= r.yy;
    in_ch.s_yz  <= r.yz;
    in_ch.s_zz  <= r.zz;
    in_ch.n_x   <= r.nx;
    in_ch.n_y   <= r.ny;
    in_ch.n_z   <= r.nz;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_splits.push_back(e);
    n_sent++;
  endtask

  // result side: random back-pressure per result
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = snk_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  always @(posedge clk) begin
    split_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_splits.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h %h %h %h", out_ch.normal_stress,
                                  out_ch.tangent_x, out_ch.tangent_y, out_ch.tangent_z));
      end else begin
        want = expected_splits.pop_front();
        check_field("normal_stress", out_ch.normal_stress, want.sigma);
        check_field("tangent_x", out_ch.tangent_x, want.tx);
        check_field("tangent_y", out_ch.tangent_y, want.ty);
        check_field("tangent_z", out_ch.tangent_z, want.tz);
      end
      n_checked++;
    end
  end

  // watchdog: cycles with no request moving on either channel
  initial begin
    int idle;
    idle = 0;
    do begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end while (idle < IDLE_LIMIT);
    $display("[%0t] watchdog: no progress for %0d cycles", $realtime, IDLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    tensor_req_t r;
    split_res_t  e;
    int          n_dir;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.s_xx  = '0;
    in_ch.s_xy  = '0;
    in_ch.s_xz  = '0;
    in_ch.s_yy  = '0;
    in_ch.s_yz  = '0;
    in_ch.s_zz  = '0;
    in_ch.n_x   = '0;
    in_ch.n_y   = '0;
    in_ch.n_z   = '0;
    src_idle    = 1'b1;
    snk_idle    = 1'b1;
    n_sent      = 0;
    n_checked   = 0;
    n_errors    = 0;

    // typed rows: zero, uniaxial, pure shear, clamp at both ends with the -2.0 code
    dir_table.push_back('{req: '0, typed: 1'b1, res: '0});
    dir_table.push_back('{req: '{xx: SONE, nx: NONE, default: '0}, typed: 1'b1,
                          res: '{sigma: SONE, default: '0}});
    dir_table.push_back('{req: '{xy: SONE, nx: NONE, default: '0}, typed: 1'b1,
                          res: '{ty: SONE, default: '0}});
    dir_table.push_back('{req: '{xx: SMAX, xy: SMAX, xz: SMAX, yy: SMAX, yz: SMAX, zz: SMAX,
                                 nx: NMIN, ny: NMIN, nz: NMIN}, typed: 1'b1,
                          res: '{SMAX, SMAX, SMAX, SMAX}});
    dir_table.push_back('{req: '{xx: SMIN, xy: SMIN, xz: SMIN, yy: SMIN, yz: SMIN, zz: SMIN,
                                 nx: NMIN, ny: NMIN, nz: NMIN}, typed: 1'b1,
                          res: '{SMIN, SMIN, SMIN, SMIN}});
    // predicted rows
    dir_table.push_back('{req: '{xx: SMAX, xy: SMAX, xz: SMAX, yy: SMAX, yz: SMAX, zz: SMAX,
                                 nx: NMAX, ny: NMAX, nz: NMAX}, typed: 1'b0, res: '0});
    dir_table.push_back('{req: '{xx: SMIN, xy: SMIN, xz: SMIN, yy: SMIN, yz: SMIN, zz: SMIN,
                                 nx: NMAX, ny: NMAX, nz: NMAX}, typed: 1'b0, res: '0});
    dir_table.push_back('{req: '{xx: SMAX, xy: SMIN, xz: SMAX, yy: SMIN, yz: SMAX, zz: SMIN,
                                 nx: NMIN, ny: NMAX, nz: '0}, typed: 1'b0, res: '0});
    // round half up on positive and negative halves
    dir_table.push_back('{req: '{xx: 1, nx: NONE / 2, default: '0}, typed: 1'b0, res: '0});
    dir_table.push_back('{req: '{xx: -1, nx: NONE / 2, default: '0}, typed: 1'b0, res: '0});
    dir_table.push_back('{req: '{xx: 3, nx: NONE / 2, default: '0}, typed: 1'b0, res: '0});
    dir_table.push_back('{req: '{xx: -3, nx: NONE / 2, default: '0}, typed: 1'b0, res: '0});
    dir_table.push_back('{req: '{xx: 32'shAAAAAAAA, xy: 32'sh55555555, xz: 32'shAAAAAAAA,
                                 yy: 32'sh55555555, yz: 32'shAAAAAAAA, zz: 32'sh55555555,
                                 nx: 16'shAAAA, ny: 16'sh5555, nz: 16'shAAAA},
                          typed: 1'b0, res: '0});
    dir_table.push_back('{req: '{xx: 32'sh55555555, xy: 32'shAAAAAAAA, xz: 32'sh55555555,
                                 yy: 32'shAAAAAAAA, yz: 32'sh55555555, zz: 32'shAAAAAAAA,
                                 nx: 16'sh5555, ny: 16'shAAAA, nz: 16'sh5555},
                          typed: 1'b0, res: '0});
    // non-unit normal is used as given
    dir_table.push_back('{req: '{xx: 32'sh00012345, xy: -32'sh0000F00D, xz: 32'sh00340000,
                                 yy: -32'sh00020000, yz: 32'sh00008000, zz: 32'sh7FFF0000,
                                 nx: NONE, ny: NONE, nz: NONE}, typed: 1'b0, res: '0});
    dir_table.push_back('{req: '{yz: SONE, ny: NONE, nz: -NONE, default: '0},
                          typed: 1'b0, res: '0});
    dir_table.push_back('{req: '{yy: -SONE, zz: SMAX, ny: 16'sd11585, nz: 16'sd11585,
                                 default: '0}, typed: 1'b0, res: '0});
    dir_table.push_back('{req: '{zz: SMIN, xz: SONE, nz: -NONE, nx: NMIN, default: '0},
                          typed: 1'b0, res: '0});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      e = dir_table[i].typed ? dir_table[i].res : predict_split(dir_table[i].req);
      send_req(dir_table[i].req, e);
    end
    n_dir = n_sent;

    // four random phases: both stall, none, sink only, sender only
    for (int ph = 0; ph < 4; ph++) begin
      src_idle = (ph == 0) || (ph == 3);
      snk_idle = (ph == 0) || (ph == 2);
      if (ph == 2) begin
        // hold the sender until the pipe is empty
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_splits.size() != 0);
      end
      repeat (RAND_PHASE) begin
        r = rand_tensor();
        send_req(r, predict_split(r));
      end
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_splits.size() != 0);
    repeat (tnts_pkg::PIPE_STAGES + 4) @(posedge clk);
    if (expected_splits.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_splits.size()));

    $display("%0d requests (%0d directed), %0d results checked, %0d mismatches",
             n_sent, n_dir, n_checked, n_errors);
    $display("covered clamping at both ends, -2.0 normals, half-way rounding, stalls, drain");
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
